// ===== design/uid_node_id_allocator_defines.svh =====
// assertion macros for the node-id allocator
`ifndef UID_NODE_ID_ALLOCATOR_DEFINES_SVH
`define UID_NODE_ID_ALLOCATOR_DEFINES_SVH

// condition holds in the same cycle as its trigger
`define UIDNA_ASSERT_IMP(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("uidna same-cycle check failed");

// condition holds in the cycle after its trigger
`define UIDNA_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("uidna next-cycle check failed");

`endif

// ===== design/uidna_pkg.sv =====
// shared types and constants of the node-id allocator
`timescale 1ns / 1ps

package uidna_pkg;

	localparam int NID_W  = 7;
	localparam int HASH_W = 48;
	localparam int NODES  = 128;

	// request codes
	localparam logic [1:0] REQ_INFO    = 2'd0;
	localparam logic [1:0] REQ_ALLOC   = 2'd1;
	localparam logic [1:0] REQ_RESERVE = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD      = 3'd1;
	localparam logic [2:0] ST_MISMATCH = 3'd2;
	localparam logic [2:0] ST_NO_FREE  = 3'd3;
	localparam logic [2:0] ST_JFULL    = 3'd4;
	localparam logic [2:0] ST_ZERO     = 3'd5;

	// fnv-1a constants; prime is 2^40 + 0x1b3
	localparam logic [63:0] FNV_OFFSET    = 64'hcbf29ce484222325;
	localparam logic [8:0]  FNV_PRIME_LO  = 9'h1b3;
	localparam logic [4:0]  UID_MAX_BYTES = 5'd16;

	typedef enum logic [1:0] {
		CMD_BAD  = 2'd0,
		CMD_ZERO = 2'd1,
		CMD_RUN  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [1:0]          req;
		logic [NID_W-1:0]    nid;
		logic [HASH_W-1:0]   hash;
	} cmd_t;

	typedef struct packed {
		logic [NID_W-1:0] assigned;
		logic             success;
		logic [2:0]       status;
	} res_t;

endpackage

// ===== design/uidna_front.sv =====
// front end: accepts beats, checks them and hashes the uid
`timescale 1ns / 1ps

module uidna_front #(
	parameter int TOP_NODE_ID = 125
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 req_type,
	input  logic [uidna_pkg::NID_W-1:0] node_id,
	input  logic [63:0]                uid_low,
	input  logic [63:0]                uid_high,
	input  logic [4:0]                 uid_bytes,
	output logic                       push,
	output uidna_pkg::cmd_t            cmd,
	input  logic                       q_full
);
	import uidna_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_HASH = 4'b0010,
		F_FOLD = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t         state_q;
	cmd_t            cmd_q;
	logic [63:0]     h_q;
	logic [127:0]    uid_q;
	logic [4:0]      cnt_q;

	logic            accept;
	logic            bad;
	logic [4:0]      ub_sat;
	logic [4:0]      len;
	logic [63:0]     t;
	logic [63:0]     h_next;
	logic [HASH_W-1:0] h48;

	assign accept   = in_valid && (state_q == F_IDLE);
	assign in_stall = (state_q != F_IDLE);
	assign push     = (state_q == F_PUSH) && !q_full;
	assign cmd      = cmd_q;

	// request classification
	assign ub_sat = (uid_bytes > UID_MAX_BYTES) ? UID_MAX_BYTES : uid_bytes;
	assign len    = (req_type == REQ_RESERVE) ? ub_sat : UID_MAX_BYTES;
	assign bad    = (req_type != REQ_INFO && req_type != REQ_ALLOC && req_type != REQ_RESERVE)
		|| (req_type != REQ_ALLOC
			&& (node_id == '0 || node_id > NID_W'(TOP_NODE_ID)));

	// one fnv-1a byte step, prime multiply as shift plus small product
	assign t      = h_q ^ {56'b0, uid_q[7:0]};
	assign h_next = t + {t[23:0], 40'b0} + (t * {55'b0, FNV_PRIME_LO});
	assign h48    = h_q[HASH_W-1:0] ^ {40'b0, h_q[63:56]};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (bad || len == '0)
							state_q <= F_PUSH;
						else
							state_q <= F_HASH;
					end
				end
				F_HASH: begin
					if (cnt_q == 5'd1)
						state_q <= F_FOLD;
				end
				F_FOLD: state_q <= F_PUSH;
				F_PUSH: begin
					if (!q_full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.req  <= req_type;
			cmd_q.nid  <= node_id;
			cmd_q.hash <= '0;
			cmd_q.kind <= bad ? CMD_BAD : CMD_ZERO;
			h_q        <= FNV_OFFSET;
			uid_q      <= {uid_high, uid_low};
			cnt_q      <= len;
		end else if (state_q == F_HASH) begin
			h_q   <= h_next;
			uid_q <= {8'b0, uid_q[127:8]};
			cnt_q <= cnt_q - 5'd1;
		end else if (state_q == F_FOLD) begin
			cmd_q.hash <= h48;
			cmd_q.kind <= (h48 == '0) ? CMD_ZERO : CMD_RUN;
		end
	end

endmodule

// ===== design/uidna_queue.sv =====
// two-entry command queue between front and back end
`timescale 1ns / 1ps

module uidna_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  uidna_pkg::cmd_t din,
	output logic            full,
	input  logic            pop,
	output uidna_pkg::cmd_t dout,
	output logic            empty
);
	import uidna_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign dout  = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop && !empty)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push && !full)
			entry_q[wr_ptr_q] <= din;
	end

endmodule

// ===== design/uidna_back.sv =====
// back end: table scan, decision, registration and result register
`timescale 1ns / 1ps

module uidna_back #(
	parameter int TOP_NODE_ID   = 125,
	parameter int JOURNAL_SLOTS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	output logic                        q_pop,
	input  uidna_pkg::cmd_t             q_cmd,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [uidna_pkg::NID_W-1:0] assigned_node_id,
	output logic                        success,
	output logic [2:0]                  status,
	output logic                        journal_full
);
	import uidna_pkg::*;

	localparam int SW = $clog2(JOURNAL_SLOTS + 1);

	typedef enum logic [4:0] {
		B_IDLE   = 5'b00001,
		B_SCAN   = 5'b00010,
		B_DRAIN  = 5'b00100,
		B_DECIDE = 5'b01000,
		B_DONE   = 5'b10000
	} bstate_t;

	bstate_t           state_q;
	cmd_t              cmd_q;
	res_t              res_q;
	logic [NODES-1:0]  valid_q;
	logic [SW-1:0]     slots_q;
	logic [NID_W-1:0]  addr_q;
	logic [NID_W-1:0]  found_q;
	logic [NID_W-1:0]  free_q;
	logic              vld_s1;
	logic [NID_W-1:0]  id_s1;
	logic [HASH_W-1:0] rd_data_s1;
	logic              out_valid_q;

	logic [HASH_W-1:0] hash_mem [NODES];

	logic              reg_req;
	logic [NID_W-1:0]  reg_id;
	logic              slots_full;
	logic              do_reg;
	logic              out_load;
	res_t              dec_res;
	logic [NODES-1:0]  clr_mask;
	logic [NODES-1:0]  set_mask;

	assign q_pop      = (state_q == B_IDLE) && !q_empty;
	assign slots_full = (slots_q >= SW'(JOURNAL_SLOTS));
	assign out_load   = (state_q == B_DONE) && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;

	// decision once the scan has found the match and the highest free id
	always_comb begin
		reg_req = 1'b0;
		reg_id  = cmd_q.nid;
		dec_res = '{assigned: '0, success: 1'b0, status: ST_BAD};
		case (cmd_q.req)
			REQ_INFO: begin
				if (valid_q[cmd_q.nid]) begin
					if (found_q == cmd_q.nid)
						dec_res = '{assigned: cmd_q.nid, success: 1'b1, status: ST_OK};
					else
						dec_res = '{assigned: found_q, success: 1'b0, status: ST_MISMATCH};
				end else begin
					reg_req = 1'b1;
				end
			end
			REQ_ALLOC: begin
				if (found_q != '0)
					dec_res = '{assigned: found_q, success: 1'b1, status: ST_OK};
				else if (free_q == '0)
					dec_res = '{assigned: '0, success: 1'b0, status: ST_NO_FREE};
				else begin
					reg_req = 1'b1;
					reg_id  = free_q;
				end
			end
			default: begin
				if (found_q == cmd_q.nid)
					dec_res = '{assigned: cmd_q.nid, success: 1'b1, status: ST_OK};
				else
					reg_req = 1'b1;
			end
		endcase
		if (reg_req) begin
			if (slots_full)
				dec_res = '{assigned: '0, success: 1'b0, status: ST_JFULL};
			else
				dec_res = '{assigned: reg_id, success: 1'b1, status: ST_OK};
		end
	end

	assign do_reg = (state_q == B_DECIDE) && reg_req && !slots_full;

	// old holder of the hash drops out, new id is marked
	assign set_mask = NODES'(1) << reg_id;
	assign clr_mask = (found_q != '0 && found_q != reg_id) ? (NODES'(1) << found_q) : '0;

	// sequencer and table control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			valid_q     <= '0;
			slots_q     <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == B_SCAN);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (do_reg) begin
				slots_q <= slots_q + SW'(1);
				valid_q <= (valid_q & ~clr_mask) | set_mask;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty)
						state_q <= (q_cmd.kind == CMD_RUN) ? B_SCAN : B_DONE;
				end
				B_SCAN: begin
					if (addr_q == NID_W'(1))
						state_q <= B_DRAIN;
				end
				B_DRAIN:  state_q <= B_DECIDE;
				B_DECIDE: state_q <= B_DONE;
				B_DONE: begin
					if (out_load)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// scan datapath and result capture
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q   <= q_cmd;
			addr_q  <= NID_W'(TOP_NODE_ID);
			found_q <= '0;
			free_q  <= '0;
			res_q   <= '{assigned: '0, success: 1'b0,
				status: (q_cmd.kind == CMD_ZERO) ? ST_ZERO : ST_BAD};
		end else begin
			if (state_q == B_SCAN) begin
				addr_q <= addr_q - NID_W'(1);
				if (!valid_q[addr_q] && free_q == '0)
					free_q <= addr_q;
			end
			if (vld_s1 && valid_q[id_s1] && rd_data_s1 == cmd_q.hash && found_q == '0)
				found_q <= id_s1;
			if (state_q == B_DECIDE)
				res_q <= dec_res;
		end
		id_s1 <= addr_q;
		if (out_load) begin
			assigned_node_id <= res_q.assigned;
			success          <= res_q.success;
			status           <= res_q.status;
			journal_full     <= slots_full;
		end
	end

	// hash table memory
	always_ff @(posedge clk) begin
		if (do_reg)
			hash_mem[reg_id] <= cmd_q.hash;
		rd_data_s1 <= hash_mem[addr_q];
	end

endmodule

// ===== design/uid_node_id_allocator.sv =====
// Node-id allocator top level: front end, command queue and back end.
// From input beat to result beat: one fnv step per uid byte, then one table entry read
// per cycle from TOP_NODE_ID down to 1. A bad request or empty uid skips hashing and the
// table scan, and a zero hash skips the table scan.
// The table scan limits the beat rate; hashing of the next beat overlaps it.
// Reset: valid bits and the journal count clear at once; no clearing pass.
`timescale 1ns / 1ps
`include "uid_node_id_allocator_defines.svh"

module uid_node_id_allocator #(
	parameter int TOP_NODE_ID   = 125,
	parameter int JOURNAL_SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [6:0]  node_id,
	input  logic [63:0] uid_low,
	input  logic [63:0] uid_high,
	input  logic [4:0]  uid_bytes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  assigned_node_id,
	output logic        success,
	output logic [2:0]  status,
	output logic        journal_full
);
	import uidna_pkg::*;

	logic push;
	logic q_full;
	logic q_empty;
	logic q_pop;
	cmd_t f_cmd;
	cmd_t q_cmd;

	// hashing front end
	uidna_front #(
		.TOP_NODE_ID(TOP_NODE_ID)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.node_id  (node_id),
		.uid_low  (uid_low),
		.uid_high (uid_high),
		.uid_bytes(uid_bytes),
		.push     (push),
		.cmd      (f_cmd),
		.q_full   (q_full)
	);

	// decoupling queue
	uidna_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (f_cmd),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_cmd),
		.empty (q_empty)
	);

	// table back end
	uidna_back #(
		.TOP_NODE_ID  (TOP_NODE_ID),
		.JOURNAL_SLOTS(JOURNAL_SLOTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.q_cmd           (q_cmd),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.assigned_node_id(assigned_node_id),
		.success         (success),
		.status          (status),
		.journal_full    (journal_full)
	);

	// checks
	`UIDNA_ASSERT_IMP(a_no_overflow, q_full, !push)
	`UIDNA_ASSERT_IMP(a_ok_success, out_valid, success == (status == ST_OK))
	`UIDNA_ASSERT_IMP(a_fail_zero_id, out_valid && !success && status != ST_MISMATCH, assigned_node_id == '0)
	`UIDNA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule
